>>> rtl/ppc_pkg.sv
// Shared types, constants and divider table for the PWM prescaler and period calculator.
package ppc_pkg;

  // Field widths
  localparam int unsigned MOD_W      = 2;
  localparam int unsigned FREQ_W     = 27;
  localparam int unsigned DUTY_W     = 17;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned DPROD_W    = 11;
  localparam int unsigned THR_W      = 11;
  localparam int unsigned PROD_W     = DPROD_W + FREQ_W;
  localparam int unsigned DIVIDEND_W = 27;
  localparam int unsigned TRIAL_W    = DIVIDEND_W + PERIOD_W;
  localparam int unsigned CMP_W      = PERIOD_W + DUTY_W;

  // One quotient bit per divider stage
  localparam int unsigned DIV_STAGES = PERIOD_W;

  // Time base clock over the period
  localparam logic [DIVIDEND_W-1:0] DIVIDEND = 27'd100_000_000;

  // Q16 full duty
  localparam logic [DUTY_W-1:0] FULL_DUTY = 17'd65536;

  // Distinct divider products below the fallback, in ascending order
  localparam int unsigned NUM_HIT = 35;
  localparam int unsigned ENT_W   = 6;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUTY    = 2'd1,
    ST_UNREACH = 2'd2
  } status_e;

  typedef struct packed {
    logic [DPROD_W-1:0] prod;
    logic [IDX_W-1:0]   clk_idx;
    logic [IDX_W-1:0]   fast_idx;
    logic [THR_W-1:0]   thresh;
  } div_entry_t;

  // Sideband that rides along with a beat through the pipeline
  typedef struct packed {
    logic [MOD_W-1:0]  module_sel;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [IDX_W-1:0]  clk_idx;
    logic [IDX_W-1:0]  fast_idx;
    status_e           status;
  } ppc_side_t;

  typedef struct packed {
    logic [DIVIDEND_W-1:0] rem;
    logic [DIVIDEND_W-1:0] divisor;
    logic [PERIOD_W-1:0]   quot;
    ppc_side_t             side;
  } div_beat_t;

  // Product d, first pair in row order giving d, and the smallest frequency f
  // with d*f*655350 > 1e9 (that is d*f >= 1526). Anything past the list is
  // the fallback pair with d = 1792.
  function automatic div_entry_t div_entry(input logic [ENT_W-1:0] k);
    div_entry_t e;
    case (k)
      6'd0:    e = '{prod: 11'd1,    clk_idx: 3'd0, fast_idx: 3'd0, thresh: 11'd1526};
      6'd1:    e = '{prod: 11'd2,    clk_idx: 3'd0, fast_idx: 3'd1, thresh: 11'd763};
      6'd2:    e = '{prod: 11'd4,    clk_idx: 3'd0, fast_idx: 3'd2, thresh: 11'd382};
      6'd3:    e = '{prod: 11'd6,    clk_idx: 3'd0, fast_idx: 3'd3, thresh: 11'd255};
      6'd4:    e = '{prod: 11'd8,    clk_idx: 3'd0, fast_idx: 3'd4, thresh: 11'd191};
      6'd5:    e = '{prod: 11'd10,   clk_idx: 3'd0, fast_idx: 3'd5, thresh: 11'd153};
      6'd6:    e = '{prod: 11'd12,   clk_idx: 3'd0, fast_idx: 3'd6, thresh: 11'd128};
      6'd7:    e = '{prod: 11'd14,   clk_idx: 3'd0, fast_idx: 3'd7, thresh: 11'd109};
      6'd8:    e = '{prod: 11'd16,   clk_idx: 3'd1, fast_idx: 3'd4, thresh: 11'd96};
      6'd9:    e = '{prod: 11'd20,   clk_idx: 3'd1, fast_idx: 3'd5, thresh: 11'd77};
      6'd10:   e = '{prod: 11'd24,   clk_idx: 3'd1, fast_idx: 3'd6, thresh: 11'd64};
      6'd11:   e = '{prod: 11'd28,   clk_idx: 3'd1, fast_idx: 3'd7, thresh: 11'd55};
      6'd12:   e = '{prod: 11'd32,   clk_idx: 3'd2, fast_idx: 3'd4, thresh: 11'd48};
      6'd13:   e = '{prod: 11'd40,   clk_idx: 3'd2, fast_idx: 3'd5, thresh: 11'd39};
      6'd14:   e = '{prod: 11'd48,   clk_idx: 3'd2, fast_idx: 3'd6, thresh: 11'd32};
      6'd15:   e = '{prod: 11'd56,   clk_idx: 3'd2, fast_idx: 3'd7, thresh: 11'd28};
      6'd16:   e = '{prod: 11'd64,   clk_idx: 3'd3, fast_idx: 3'd4, thresh: 11'd24};
      6'd17:   e = '{prod: 11'd80,   clk_idx: 3'd3, fast_idx: 3'd5, thresh: 11'd20};
      6'd18:   e = '{prod: 11'd96,   clk_idx: 3'd3, fast_idx: 3'd6, thresh: 11'd16};
      6'd19:   e = '{prod: 11'd112,  clk_idx: 3'd3, fast_idx: 3'd7, thresh: 11'd14};
      6'd20:   e = '{prod: 11'd128,  clk_idx: 3'd4, fast_idx: 3'd4, thresh: 11'd12};
      6'd21:   e = '{prod: 11'd160,  clk_idx: 3'd4, fast_idx: 3'd5, thresh: 11'd10};
      6'd22:   e = '{prod: 11'd192,  clk_idx: 3'd4, fast_idx: 3'd6, thresh: 11'd8};
      6'd23:   e = '{prod: 11'd224,  clk_idx: 3'd4, fast_idx: 3'd7, thresh: 11'd7};
      6'd24:   e = '{prod: 11'd256,  clk_idx: 3'd5, fast_idx: 3'd4, thresh: 11'd6};
      6'd25:   e = '{prod: 11'd320,  clk_idx: 3'd5, fast_idx: 3'd5, thresh: 11'd5};
      6'd26:   e = '{prod: 11'd384,  clk_idx: 3'd5, fast_idx: 3'd6, thresh: 11'd4};
      6'd27:   e = '{prod: 11'd448,  clk_idx: 3'd5, fast_idx: 3'd7, thresh: 11'd4};
      6'd28:   e = '{prod: 11'd512,  clk_idx: 3'd6, fast_idx: 3'd4, thresh: 11'd3};
      6'd29:   e = '{prod: 11'd640,  clk_idx: 3'd6, fast_idx: 3'd5, thresh: 11'd3};
      6'd30:   e = '{prod: 11'd768,  clk_idx: 3'd6, fast_idx: 3'd6, thresh: 11'd2};
      6'd31:   e = '{prod: 11'd896,  clk_idx: 3'd6, fast_idx: 3'd7, thresh: 11'd2};
      6'd32:   e = '{prod: 11'd1024, clk_idx: 3'd7, fast_idx: 3'd4, thresh: 11'd2};
      6'd33:   e = '{prod: 11'd1280, clk_idx: 3'd7, fast_idx: 3'd5, thresh: 11'd2};
      6'd34:   e = '{prod: 11'd1536, clk_idx: 3'd7, fast_idx: 3'd6, thresh: 11'd1};
      default: e = '{prod: 11'd1792, clk_idx: 3'd7, fast_idx: 3'd7, thresh: 11'd0};
    endcase
    return e;
  endfunction

endpackage

>>> rtl/pwm_prescaler_period_calc.sv
// Pipeline: 4 front stages, 16 divider stages with one quotient bit each, and 1
// compare/output stage. Throughput: one beat per cycle while out_stall_i is low;
// every stage advances when empty or when its successor moves, so bubbles collapse
// and a waiting result blocks input only once every stage behind it holds a beat.
// Reset: rst_ni clears all valid bits asynchronously; payload registers are not reset.
// Each result depends only on its own input beat.
module pwm_prescaler_period_calc import ppc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [MOD_W-1:0]    module_select_i,
  input  logic [FREQ_W-1:0]   frequency_hz_i,
  input  logic [DUTY_W-1:0]   duty_a_i,
  input  logic [DUTY_W-1:0]   duty_b_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [MOD_W-1:0]    module_echo_o,
  output logic [IDX_W-1:0]    clock_div_index_o,
  output logic [IDX_W-1:0]    fast_div_index_o,
  output logic [PERIOD_W-1:0] period_count_o,
  output logic [PERIOD_W-1:0] compare_a_o,
  output logic [PERIOD_W-1:0] compare_b_o
);

  // Stage enables and valids
  logic en1, en2, en3, en4, en_out;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;

  // Stage 1: threshold compares and input checks
  logic [NUM_HIT-1:0] hit_d, s1_hit_q;
  logic [FREQ_W-1:0]  s1_freq_q;
  ppc_side_t          side_d, s1_side_q;

  // Stage 2: divider pair selection
  logic [NUM_HIT:0]   onehot;
  div_entry_t         sel;
  ppc_side_t          s2_side_d, s2_side_q;
  logic [DPROD_W-1:0] s2_dprod_q;
  logic [FREQ_W-1:0]  s2_freq_q;

  // Stage 3: product d*f
  ppc_side_t          s3_side_q;
  logic [PROD_W-1:0]  s3_prod_q;

  // Stage 4: range check and divisor
  ppc_side_t             s4_side_d, s4_side_q;
  logic [DIVIDEND_W-1:0] s4_divisor_q;

  // Divider hookup
  div_beat_t div_in, div_out;
  logic      div_in_stall, div_out_v;

  // Output stage
  logic                ok;
  logic [CMP_W-1:0]    cmp_a_full, cmp_b_full;
  status_e             status_q;
  logic [MOD_W-1:0]    module_q;
  logic [IDX_W-1:0]    clk_idx_q, fast_idx_q;
  logic [PERIOD_W-1:0] period_q, cmp_a_q, cmp_b_q;

  // Handshake chain from the output back to the input
  assign en_out     = !out_v_q || !out_stall_i;
  assign en4        = !s4_v_q || !div_in_stall;
  assign en3        = !s3_v_q || en4;
  assign en2        = !s2_v_q || en3;
  assign en1        = !s1_v_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1)    s1_v_q  <= in_valid_i;
      if (en2)    s2_v_q  <= s1_v_q;
      if (en3)    s3_v_q  <= s2_v_q;
      if (en4)    s4_v_q  <= s3_v_q;
      if (en_out) out_v_q <= div_out_v;
    end
  end

  // Compare frequency against every product threshold
  for (genvar k = 0; k < NUM_HIT; k++) begin : g_hit
    localparam div_entry_t Ent = div_entry(ENT_W'(k));
    assign hit_d[k] = frequency_hz_i >= FREQ_W'(Ent.thresh);
  end

  // Duty check first, then zero frequency
  always_comb begin
    side_d            = '0;
    side_d.module_sel = module_select_i;
    side_d.duty_a     = duty_a_i;
    side_d.duty_b     = duty_b_i;
    if (duty_a_i > FULL_DUTY || duty_b_i > FULL_DUTY) begin
      side_d.status = ST_DUTY;
    end else if (frequency_hz_i == '0) begin
      side_d.status = ST_UNREACH;
    end else begin
      side_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_hit_q  <= hit_d;
      s1_freq_q <= frequency_hz_i;
      s1_side_q <= side_d;
    end
  end

  // Hits form a thermometer; its lowest set bit is the smallest product that works
  always_comb begin
    onehot[0]       = s1_hit_q[0];
    for (int k = 1; k < NUM_HIT; k++) begin
      onehot[k] = s1_hit_q[k] && !s1_hit_q[k-1];
    end
    onehot[NUM_HIT] = !s1_hit_q[NUM_HIT-1];
  end

  always_comb begin
    sel = '0;
    for (int k = 0; k <= NUM_HIT; k++) begin
      if (onehot[k]) begin
        sel = div_entry_t'(sel | div_entry(ENT_W'(k)));
      end
    end
    s2_side_d          = s1_side_q;
    s2_side_d.clk_idx  = sel.clk_idx;
    s2_side_d.fast_idx = sel.fast_idx;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_side_q  <= s2_side_d;
      s2_dprod_q <= sel.prod;
      s2_freq_q  <= s1_freq_q;
    end
  end

  // Multiply divider product by frequency
  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_side_q <= s2_side_q;
      s3_prod_q <= PROD_W'(s2_dprod_q) * PROD_W'(s2_freq_q);
    end
  end

  // Flag a product above the dividend as unreachable (period of zero)
  always_comb begin
    s4_side_d = s3_side_q;
    if (s3_side_q.status == ST_OK && s3_prod_q > PROD_W'(DIVIDEND)) begin
      s4_side_d.status = ST_UNREACH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_side_q    <= s4_side_d;
      s4_divisor_q <= s3_prod_q[DIVIDEND_W-1:0];
    end
  end

  assign div_in = '{rem: DIVIDEND, divisor: s4_divisor_q, quot: '0, side: s4_side_q};

  ppc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s4_v_q),
    .in_stall_o  (div_in_stall),
    .in_beat_i   (div_in),
    .out_valid_o (div_out_v),
    .out_stall_i (!en_out),
    .out_beat_o  (div_out)
  );

  // Compare values and zeroing of failed results
  assign ok         = div_out.side.status == ST_OK;
  assign cmp_a_full = CMP_W'(div_out.quot) * CMP_W'(div_out.side.duty_a);
  assign cmp_b_full = CMP_W'(div_out.quot) * CMP_W'(div_out.side.duty_b);

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      status_q   <= div_out.side.status;
      module_q   <= div_out.side.module_sel;
      clk_idx_q  <= ok ? div_out.side.clk_idx : '0;
      fast_idx_q <= ok ? div_out.side.fast_idx : '0;
      period_q   <= ok ? div_out.quot : '0;
      cmp_a_q    <= ok ? cmp_a_full[PERIOD_W +: PERIOD_W] : '0;
      cmp_b_q    <= ok ? cmp_b_full[PERIOD_W +: PERIOD_W] : '0;
    end
  end

  assign out_valid_o       = out_v_q;
  assign status_o          = status_q;
  assign module_echo_o     = module_q;
  assign clock_div_index_o = clk_idx_q;
  assign fast_div_index_o  = fast_idx_q;
  assign period_count_o    = period_q;
  assign compare_a_o       = cmp_a_q;
  assign compare_b_o       = cmp_b_q;

`ifndef ASSERT_OFF
  // A failed result carries no settings
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (clock_div_index_o == '0 && fast_div_index_o == '0 && period_count_o == '0
       && compare_a_o == '0 && compare_b_o == '0))
    else $error("failed result carries nonzero settings");

  // A good result has a nonzero period and compares within it
  a_ok_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK) |->
      (period_count_o != '0 && compare_a_o <= period_count_o
       && compare_b_o <= period_count_o))
    else $error("good result with zero period or compare past period");

  // Input is never throttled while the output side takes beats
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");
`endif

endmodule

>>> rtl/ppc_div.sv
// Pipelined restoring divider: one quotient bit per stage, sideband carried along.
module ppc_div import ppc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  div_beat_t in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output div_beat_t out_beat_o
);

  div_beat_t              st_q  [DIV_STAGES];
  div_beat_t              chain [DIV_STAGES+1];
  div_beat_t              nxt   [DIV_STAGES];
  logic [TRIAL_W-1:0]     trial [DIV_STAGES];
  logic [DIV_STAGES-1:0]  take;
  logic [DIV_STAGES-1:0]  v_q;
  logic [DIV_STAGES:0]    vchain;
  logic [DIV_STAGES:0]    en;

  // Link stage outputs into the next stage inputs
  assign chain[0] = in_beat_i;
  assign vchain   = {v_q, in_valid_i};
  assign en[DIV_STAGES] = !out_stall_i;

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_link
    assign chain[j+1] = st_q[j];
    // Advance a stage when it is empty or its successor moves
    assign en[j] = !v_q[j] || en[j+1];
  end

  // Try to subtract the shifted divisor, set the quotient bit on success
  always_comb begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      trial[j] = TRIAL_W'(chain[j].divisor) << (DIV_STAGES - 1 - j);
      take[j]  = TRIAL_W'(chain[j].rem) >= trial[j];
      nxt[j]   = chain[j];
      if (take[j]) begin
        nxt[j].rem = chain[j].rem - trial[j][DIVIDEND_W-1:0];
        nxt[j].quot[DIV_STAGES-1-j] = 1'b1;
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int j = 0; j < DIV_STAGES; j++) begin
        if (en[j]) begin
          v_q[j] <= vchain[j];
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (en[j]) begin
        st_q[j] <= nxt[j];
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[DIV_STAGES-1];
  assign out_beat_o  = chain[DIV_STAGES];

`ifndef ASSERT_OFF
  // Quotient and remainder always rebuild the dividend
  a_div_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (TRIAL_W'(out_beat_o.quot) * TRIAL_W'(out_beat_o.divisor)
                     + TRIAL_W'(out_beat_o.rem) == TRIAL_W'(DIVIDEND)))
    else $error("divider quotient and remainder do not rebuild the dividend");

  // Remainder is reduced whenever the quotient fits
  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_beat_o.divisor != '0)
     && ((TRIAL_W'(out_beat_o.divisor) << PERIOD_W) > TRIAL_W'(DIVIDEND)))
    |-> (out_beat_o.rem < out_beat_o.divisor))
    else $error("divider remainder not below divisor");

  // Pipeline never throttles while the output side moves
  a_div_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("divider stalls input while output is free");
`endif

endmodule

>>> tb/tb.sv
// Self-checking bench for the PWM prescaler and period calculator.
`timescale 1ns / 1ps

module tb import ppc_pkg::*; ();

  localparam longint unsigned TB_CLOCK_HZ  = 64'd100_000_000;
  localparam longint unsigned CYCLE_SCALE  = 64'd1_000_000_000;
  localparam longint unsigned MIN_SCALE    = 64'd655_350;
  localparam longint unsigned FALLBACK_DIV = 64'd1792;
  localparam int              RANDOM_REQS  = 1530;
  localparam int              PAUSE_AT     = 900;
  localparam int              HOLD_AT      = 300;
  localparam int              HOLD_CYCLES  = 250;
  localparam int              DRAIN_CYCLES = 40;
  localparam int              CYCLE_LIMIT  = 200_000;

  typedef struct {
    logic                is_pause;
    logic [MOD_W-1:0]    mod;
    logic [FREQ_W-1:0]   freq;
    logic [DUTY_W-1:0]   duty_a;
    logic [DUTY_W-1:0]   duty_b;
  } pwm_req_t;

  typedef struct packed {
    status_e             status;
    logic [MOD_W-1:0]    mod;
    logic [IDX_W-1:0]    cdiv;
    logic [IDX_W-1:0]    fdiv;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] cmp_a;
    logic [PERIOD_W-1:0] cmp_b;
  } pwm_setting_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [MOD_W-1:0]    module_select = '0;
  logic [FREQ_W-1:0]   frequency_hz = '0;
  logic [DUTY_W-1:0]   duty_a = '0;
  logic [DUTY_W-1:0]   duty_b = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          status;
  logic [MOD_W-1:0]    module_echo;
  logic [IDX_W-1:0]    clock_div_index;
  logic [IDX_W-1:0]    fast_div_index;
  logic [PERIOD_W-1:0] period_count;
  logic [PERIOD_W-1:0] compare_a;
  logic [PERIOD_W-1:0] compare_b;

  pwm_req_t     request_q[$];
  pwm_setting_t setting_q[$];
  logic         in_taken = 1'b0;
  int           n_requests = 0;
  int           n_accepted = 0;
  int           n_results = 0;
  int           mismatches = 0;
  int           cycle_count = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;

  pwm_prescaler_period_calc u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .module_select_i   (module_select),
    .frequency_hz_i    (frequency_hz),
    .duty_a_i          (duty_a),
    .duty_b_i          (duty_b),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_o          (status),
    .module_echo_o     (module_echo),
    .clock_div_index_o (clock_div_index),
    .fast_div_index_o  (fast_div_index),
    .period_count_o    (period_count),
    .compare_a_o       (compare_a),
    .compare_b_o       (compare_b)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Search the divider pairs, then derive the period and both compare values
  function automatic pwm_setting_t predict_setting(input pwm_req_t r);
    pwm_setting_t res;
    logic [63:0]  d;
    logic [63:0]  best;
    logic [63:0]  per;
    int           best_c;
    int           best_f;
    res = '0;
    res.status = ST_OK;
    res.mod = r.mod;
    if (r.duty_a > FULL_DUTY || r.duty_b > FULL_DUTY) begin
      res.status = ST_DUTY;
    end else if (r.freq == '0) begin
      res.status = ST_UNREACH;
    end else begin
      best = FALLBACK_DIV;
      best_c = 7;
      best_f = 7;
      for (int i = 0; i < 8; i++) begin
        for (int j = 0; j < 8; j++) begin
          d = (64'd1 << i) * ((j == 0) ? 64'd1 : 64'(2 * j));
          if (d < best && d * r.freq * MIN_SCALE > CYCLE_SCALE) begin
            best = d;
            best_c = i;
            best_f = j;
          end
        end
      end
      per = TB_CLOCK_HZ / (best * r.freq);
      if (per == 0) begin
        res.status = ST_UNREACH;
      end else begin
        res.cdiv = best_c[IDX_W-1:0];
        res.fdiv = best_f[IDX_W-1:0];
        res.period = per[PERIOD_W-1:0];
        res.cmp_a = 16'((per * r.duty_a) >> 16);
        res.cmp_b = 16'((per * r.duty_b) >> 16);
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_req(input logic [MOD_W-1:0] m, input logic [FREQ_W-1:0] f,
                           input logic [DUTY_W-1:0] da, input logic [DUTY_W-1:0] db);
    pwm_req_t r;
    r.is_pause = 1'b0;
    r.mod = m;
    r.freq = f;
    r.duty_a = da;
    r.duty_b = db;
    request_q.push_back(r);
    n_requests++;
  endtask

  // Offer request beats; hold a stalled beat, idle at random outside the calm window
  always @(negedge clk_i) begin : drive_requests
    pwm_req_t nxt;
    logic     offer;
    logic     calm;
    if (rst_ni && !(in_valid && !in_taken)) begin
      offer = 1'b0;
      calm = (n_accepted >= 700 && n_accepted < 1000);
      // Release a pause marker only once every pending setting has come back
      if (request_q.size() != 0 && request_q[0].is_pause && setting_q.size() == 0)
        void'(request_q.pop_front());
      if (request_q.size() != 0 && !request_q[0].is_pause &&
          (calm || $urandom_range(99) >= 30)) begin
        nxt = request_q.pop_front();
        offer = 1'b1;
        module_select <= nxt.mod;
        frequency_hz <= nxt.freq;
        duty_a <= nxt.duty_a;
        duty_b <= nxt.duty_b;
      end
      in_valid <= offer;
    end
  end

  // Stall at random outside a calm window; one long hold-off backs up the pipeline
  always @(negedge clk_i) begin : drive_stall
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_results >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (n_results >= 700 && n_results < 1000) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 30);
    end
  end

  // Score result beats against the oldest setting, then record accepted requests
  always @(posedge clk_i) begin : score_beats
    pwm_req_t     seen;
    pwm_setting_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (setting_q.size() == 0) begin
          $error("result beat with no setting pending: status %0d module %0d",
                 status, module_echo);
          mismatches++;
        end else begin
          want = setting_q.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("module_echo", 64'(want.mod), 64'(module_echo));
          check_field("clock_div_index", 64'(want.cdiv), 64'(clock_div_index));
          check_field("fast_div_index", 64'(want.fdiv), 64'(fast_div_index));
          check_field("period_count", 64'(want.period), 64'(period_count));
          check_field("compare_a", 64'(want.cmp_a), 64'(compare_a));
          check_field("compare_b", 64'(want.cmp_b), 64'(compare_b));
        end
      end
      if (in_valid && !in_stall) begin
        seen.is_pause = 1'b0;
        seen.mod = module_select;
        seen.freq = frequency_hz;
        seen.duty_a = duty_a;
        seen.duty_b = duty_b;
        setting_q.push_back(predict_setting(seen));
        n_accepted++;
      end
    end
    in_taken <= rst_ni && in_valid && !in_stall;
  end

  // Bound the run
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    pwm_req_t mark;
    pwm_req_t r;
    int       sel;

    // Directed: table edges, duty limits, unreachable and rejected requests
    queue_req(2'd0, 27'd1, 17'd0, 17'd65536);
    queue_req(2'd1, 27'd1526, 17'd32768, 17'd65536);
    queue_req(2'd2, 27'd1525, 17'd65536, 17'd0);
    queue_req(2'd3, 27'd2, 17'd12345, 17'd54321);
    queue_req(2'd0, 27'd763, 17'd1, 17'd65535);
    queue_req(2'd1, 27'd762, 17'd65536, 17'd65536);
    queue_req(2'd2, 27'd100_000_000, 17'd65536, 17'd32768);
    queue_req(2'd3, 27'd100_000_001, 17'd0, 17'd0);
    queue_req(2'd0, 27'h7FF_FFFF, 17'd65536, 17'd65536);
    queue_req(2'd1, 27'd0, 17'd100, 17'd200);
    queue_req(2'd2, 27'd1000, 17'd65537, 17'd0);
    queue_req(2'd3, 27'd1000, 17'd0, 17'd65537);
    queue_req(2'd0, 27'd0, 17'h1_FFFF, 17'h1_FFFF);
    queue_req(2'd1, 27'h7FF_FFFF, 17'h1_FFFF, 17'd0);
    queue_req(2'd2, 27'd50_000_000, 17'd21845, 17'd43690);
    queue_req(2'd3, 27'd16_000, 17'd65535, 17'd1);
    queue_req(2'd0, 27'd255, 17'd40000, 17'd20000);
    queue_req(2'd1, 27'd254, 17'd40000, 17'd20000);
    queue_req(2'd2, 27'd20_000, 17'd0, 17'd65536);
    queue_req(2'd3, 27'd3, 17'd65536, 17'd65536);

    // Random: mostly valid requests spread over the divider table
    for (int k = 0; k < RANDOM_REQS; k++) begin
      if (k == PAUSE_AT) begin
        mark.is_pause = 1'b1;
        mark.mod = '0;
        mark.freq = '0;
        mark.duty_a = '0;
        mark.duty_b = '0;
        request_q.push_back(mark);
      end
      r.mod = MOD_W'($urandom_range(3));
      sel = $urandom_range(99);
      if (sel < 3)
        r.freq = '0;
      else if (sel < 35)
        r.freq = FREQ_W'($urandom_range(2000, 1));
      else if (sel < 75)
        r.freq = FREQ_W'($urandom() >> $urandom_range(31, 5));
      else if (sel < 88)
        r.freq = FREQ_W'($urandom_range(100_000_000, 99_000_000));
      else if (sel < 94)
        r.freq = FREQ_W'($urandom_range(134_217_727, 100_000_001));
      else
        r.freq = FREQ_W'($urandom());
      sel = $urandom_range(99);
      if (sel < 7)
        r.duty_a = DUTY_W'($urandom_range(131071, 65537));
      else if (sel < 12)
        r.duty_a = (sel < 9) ? 17'd0 : FULL_DUTY;
      else
        r.duty_a = DUTY_W'($urandom_range(65536));
      sel = $urandom_range(99);
      if (sel < 6)
        r.duty_b = DUTY_W'($urandom_range(131071, 65537));
      else if (sel < 11)
        r.duty_b = (sel < 8) ? 17'd0 : FULL_DUTY;
      else
        r.duty_b = DUTY_W'($urandom_range(65536));
      queue_req(r.mod, r.freq, r.duty_a, r.duty_b);
    end

    // Hold reset low, then release it on a falling edge away from the sampling edge
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all requests in, all settings back, then let the pipeline settle
    wait (n_accepted == n_requests);
    wait (setting_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ppc_pkg.sv
rtl/ppc_div.sv
rtl/pwm_prescaler_period_calc.sv
tb/tb.sv
